// File: rtl/dptp_pkg.sv
// Package for the depth pixel to point unit.
// Holds field widths, register codes, shared structs and the depth table helpers.
// No dependencies.
package dptp_pkg;

    localparam int DEPTH_CODES_DEF = 2048;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int CODE_W  = 11;
    localparam int CX_W    = 18;
    localparam int INV_W   = 24;
    localparam int Q_W     = 24;
    localparam int DX_W    = CX_W + 1;
    localparam int MAG_D_W = CX_W;
    localparam int MAG_W   = MAG_D_W + Q_W;
    localparam int INV_SPLIT = 12;
    localparam int PROD_W  = MAG_W + INV_W - INV_SPLIT;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_SHIFT = 20;
    localparam int R_W     = SUM_W - FRAC_SHIFT;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 72;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CODE_W-1:0] NO_READING = 11'd2047;

    localparam longint ROM_NUMERATOR = 64'sd655360000000000;
    localparam longint ROM_OFFSET    = 64'sd33309495161;
    localparam longint ROM_SLOPE     = 64'sd30711016;
    localparam longint Q_MAX_L       = 64'sd8388607;
    localparam longint Q_MIN_MAG_L   = 64'sd8388608;

    localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

    localparam logic [CX_W-1:0]  CENTER_X_RST    = 18'd86863;
    localparam logic [CX_W-1:0]  CENTER_Y_RST    = 18'd62141;
    localparam logic [INV_W-1:0] INV_FOCAL_X_RST = 24'd28235;
    localparam logic [INV_W-1:0] INV_FOCAL_Y_RST = 24'd28386;

    typedef enum logic [1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_INV_FOCAL_X = 2'd2,
        REG_INV_FOCAL_Y = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CX_W-1:0]  center_x;
        logic [CX_W-1:0]  center_y;
        logic [INV_W-1:0] inv_focal_x;
        logic [INV_W-1:0] inv_focal_y;
    } cfg_t;

    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic load_s3;
        logic load_s4;
        logic load_s5;
    } stage_en_t;

    // Applies the sign of the denominator to a rounded quotient and saturates it.
    function automatic logic signed [Q_W-1:0] sat_depth(input longint den, input longint quo);
        longint res;
        if (den == 0)
        begin
            res = Q_MAX_L;
        end
        else if (den < 0)
        begin
            res = (quo >= Q_MIN_MAG_L) ? -Q_MIN_MAG_L : -quo;
        end
        else
        begin
            res = (quo > Q_MAX_L) ? Q_MAX_L : quo;
        end
        return res[Q_W-1:0];
    endfunction

endpackage

// File: rtl/depth_pixel_to_point_unit.sv
// Top level of the depth pixel to point unit: back-projects depth pixels to Q8.16 points.
// Depends on dptp_pkg, dptp_apb_regs, dptp_depth_rom, dptp_axis and dptp_pipe_ctrl.
//
//   Port group   Direction   Carries
//   s_*          in          one pixel request: column, row, raw disparity code
//   m_*          out         one point request: x, y, z and a valid-point flag
//   APB          in/out      center_x, center_y, inv_focal_x, inv_focal_y
//
// One pixel is taken every cycle while the output is not stalled, and each point passes
// through the five register stages in order: table read, magnitude
// multiply, focal multiply, rounding add and saturation. Each stage has its own valid
// bit, so a stall on m_tready only holds the stages that are full. Reset clears the
// valid bits and loads the register reset values; nothing else needs clearing.
module depth_pixel_to_point_unit
    import dptp_pkg::*;
#(
    parameter int DEPTH_CODES = DEPTH_CODES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // pixel_col, pixel_row, raw_depth, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // world_x, world_y, world_z
    output logic                  m_tuser,   // point_valid
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    stage_en_t en;

    logic [COL_W-1:0]  pixel_col;
    logic [ROW_W-1:0]  pixel_row;
    logic [CODE_W-1:0] raw_depth;
    logic              code_ok;

    logic signed [DX_W-1:0] dx_next;
    logic signed [DX_W-1:0] dy_next;
    logic signed [DX_W-1:0] dx_reg;
    logic signed [DX_W-1:0] dy_reg;
    logic                   pv1_reg;
    logic signed [Q_W-1:0]  rom_depth;
    logic signed [Q_W-1:0]  depth_s1;

    logic signed [Q_W-1:0]  z2_reg;
    logic signed [Q_W-1:0]  z3_reg;
    logic signed [Q_W-1:0]  z4_reg;
    logic signed [Q_W-1:0]  z5_reg;
    logic                   pv2_reg;
    logic                   pv3_reg;
    logic                   pv4_reg;
    logic                   pv5_reg;
    logic signed [Q_W-1:0]  world_x;
    logic signed [Q_W-1:0]  world_y;

    assign pixel_col = s_tdata[COL_W-1:0];
    assign pixel_row = s_tdata[COL_W+ROW_W-1:COL_W];
    assign raw_depth = s_tdata[COL_W+ROW_W+CODE_W-1:COL_W+ROW_W];

    assign code_ok = (raw_depth < NO_READING)
                     && ((32'(raw_depth) + 32'd1) < 32'(DEPTH_CODES));

    assign dx_next = $signed({1'b0, pixel_col, 8'b0}) - $signed({1'b0, cfg.center_x});
    assign dy_next = $signed({1'b0, pixel_row, 8'b0}) - $signed({1'b0, cfg.center_y});

    // An invalid point carries zero depth, which forces all three coordinates to zero.
    assign depth_s1 = pv1_reg ? rom_depth : '0;

    dptp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dptp_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .en        (en)
    );

    dptp_depth_rom #(
        .DEPTH_CODES (DEPTH_CODES)
    ) u_rom (
        .clk   (clk),
        .rd_en (en.load_s1),
        .code  (raw_depth),
        .depth (rom_depth)
    );

    dptp_axis u_axis_x (
        .clk       (clk),
        .en        (en),
        .offset    (dx_reg),
        .depth     (depth_s1),
        .inv_focal (cfg.inv_focal_x),
        .coord     (world_x)
    );

    dptp_axis u_axis_y (
        .clk       (clk),
        .en        (en),
        .offset    (dy_reg),
        .depth     (depth_s1),
        .inv_focal (cfg.inv_focal_y),
        .coord     (world_y)
    );

    always_ff @(posedge clk)
    begin
        if (en.load_s1)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            pv1_reg <= code_ok;
        end
        if (en.load_s2)
        begin
            z2_reg  <= depth_s1;
            pv2_reg <= pv1_reg;
        end
        if (en.load_s3)
        begin
            z3_reg  <= z2_reg;
            pv3_reg <= pv2_reg;
        end
        if (en.load_s4)
        begin
            z4_reg  <= z3_reg;
            pv4_reg <= pv3_reg;
        end
        if (en.load_s5)
        begin
            z5_reg  <= z4_reg;
            pv5_reg <= pv4_reg;
        end
    end

    assign m_tdata = {z5_reg, world_y, world_x};
    assign m_tuser = pv5_reg;

endmodule

// File: rtl/dptp_apb_regs.sv
// Configuration registers of the depth pixel to point unit behind an APB-style port.
// Depends on dptp_pkg.
module dptp_apb_regs
    import dptp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CENTER_X:    cfg_next.center_x    = pwdata[CX_W-1:0];
                REG_CENTER_Y:    cfg_next.center_y    = pwdata[CX_W-1:0];
                REG_INV_FOCAL_X: cfg_next.inv_focal_x = pwdata[INV_W-1:0];
                REG_INV_FOCAL_Y: cfg_next.inv_focal_y = pwdata[INV_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:    prdata = APB_DATA_W'(cfg_reg.center_x);
            REG_CENTER_Y:    prdata = APB_DATA_W'(cfg_reg.center_y);
            REG_INV_FOCAL_X: prdata = APB_DATA_W'(cfg_reg.inv_focal_x);
            REG_INV_FOCAL_Y: prdata = APB_DATA_W'(cfg_reg.inv_focal_y);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= CENTER_X_RST;
            cfg_reg.center_y    <= CENTER_Y_RST;
            cfg_reg.inv_focal_x <= INV_FOCAL_X_RST;
            cfg_reg.inv_focal_y <= INV_FOCAL_Y_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/dptp_depth_rom.sv
// Depth lookup table: Q8.16 metres for every raw disparity code, registered read.
// Entries are computed at elaboration. Depends on dptp_pkg.
module dptp_depth_rom
    import dptp_pkg::*;
#(
    parameter int DEPTH_CODES = DEPTH_CODES_DEF
)
(
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [CODE_W-1:0]       code,
    output logic signed [Q_W-1:0]   depth
);

    localparam int ADDR_W  = $clog2(DEPTH_CODES);
    localparam int ENTRIES = 2 ** ADDR_W;

    logic signed [Q_W-1:0] table_w [ENTRIES];
    logic [ADDR_W-1:0]     addr;
    logic signed [Q_W-1:0] depth_reg;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        localparam longint DEN = ROM_OFFSET - longint'(g) * ROM_SLOPE;
        localparam longint MAG = (DEN < 0) ? -DEN : ((DEN == 0) ? 64'sd1 : DEN);
        localparam longint QUO = (ROM_NUMERATOR + MAG / 2) / MAG;
        localparam logic signed [Q_W-1:0] ENTRY = sat_depth(DEN, QUO);
        assign table_w[g] = ENTRY;
    end

    assign addr  = ADDR_W'(code);
    assign depth = depth_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            depth_reg <= table_w[addr];
        end
    end

endmodule

// File: rtl/dptp_axis.sv
// One projection lane: rounds and saturates d * depth * inv_focal to Q8.16 over four stages.
// Depends on dptp_pkg.
module dptp_axis
    import dptp_pkg::*;
(
    input  logic                    clk,
    input  stage_en_t               en,
    input  logic signed [DX_W-1:0]  offset,
    input  logic signed [Q_W-1:0]   depth,
    input  logic [INV_W-1:0]        inv_focal,
    output logic signed [Q_W-1:0]   coord
);

    logic [MAG_D_W-1:0]    offset_mag;
    logic [Q_W-1:0]        depth_mag;
    logic [MAG_W-1:0]      mag_reg;
    logic                  neg2_reg;
    logic [PROD_W-1:0]     hi_reg;
    logic [PROD_W-1:0]     lo_reg;
    logic                  neg3_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  neg4_reg;
    logic [R_W-1:0]        rounded;
    logic signed [Q_W-1:0] coord_next;
    logic signed [Q_W-1:0] coord_reg;

    logic signed [DX_W-1:0] offset_neg;
    logic signed [Q_W-1:0]  depth_neg;

    assign offset_neg = -offset;
    assign depth_neg  = -depth;
    assign offset_mag = offset[DX_W-1] ? offset_neg[MAG_D_W-1:0] : offset[MAG_D_W-1:0];
    assign depth_mag  = depth[Q_W-1] ? depth_neg : depth;

    assign rounded = sum_reg[SUM_W-1:FRAC_SHIFT];

    always_comb
    begin
        if (neg4_reg && (rounded != '0))
        begin
            if (rounded >= R_W'(Q_MIN_MAG_L))
            begin
                coord_next = Q_MIN;
            end
            else
            begin
                coord_next = -$signed(rounded[Q_W-1:0]);
            end
        end
        else if (rounded > R_W'(Q_MAX_L))
        begin
            coord_next = Q_MAX;
        end
        else
        begin
            coord_next = $signed(rounded[Q_W-1:0]);
        end
    end

    assign coord = coord_reg;

    always_ff @(posedge clk)
    begin
        if (en.load_s2)
        begin
            mag_reg  <= MAG_W'(offset_mag) * MAG_W'(depth_mag);
            neg2_reg <= offset[DX_W-1] != depth[Q_W-1];
        end
        if (en.load_s3)
        begin
            hi_reg   <= PROD_W'(mag_reg) * PROD_W'(inv_focal[INV_W-1:INV_SPLIT]);
            lo_reg   <= PROD_W'(mag_reg) * PROD_W'(inv_focal[INV_SPLIT-1:0]);
            neg3_reg <= neg2_reg;
        end
        if (en.load_s4)
        begin
            sum_reg  <= SUM_W'(hi_reg) + SUM_W'(lo_reg >> INV_SPLIT)
                        + (SUM_W'(1) << (FRAC_SHIFT - 1));
            neg4_reg <= neg3_reg;
        end
        if (en.load_s5)
        begin
            coord_reg <= coord_next;
        end
    end

endmodule

// File: rtl/dptp_pipe_ctrl.sv
// Valid bits and stage load enables of the five-stage pipeline.
// A stage loads when it is empty or the next stage loads. Depends on dptp_pkg.
module dptp_pipe_ctrl
    import dptp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output stage_en_t en
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   ready;

    always_comb
    begin
        ready[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (ready[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    assign in_ready   = ready[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign en.load_s1 = ready[0];
    assign en.load_s2 = ready[1];
    assign en.load_s3 = ready[2];
    assign en.load_s4 = ready[3];
    assign en.load_s5 = ready[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

// File: rtl/dptp_checker.sv
// Port-level checks for the depth pixel to point unit, bound to the top level.
// Depends on dptp_pkg and depth_pixel_to_point_unit.
module dptp_checker
    import dptp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  m_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled point request changed");

    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("point without a reading has nonzero coordinates");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while the output accepts");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("point request right after reset");

endmodule

bind depth_pixel_to_point_unit dptp_checker u_checker (.*);
